>>> src/ssll_pkg.sv
// Package of shared constants, types and helpers for the sorted static linked list.
`timescale 1ns / 1ps

package ssll_pkg;

	localparam int SLOTS    = 64;
	localparam int KEY_BITS = 32;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int LINK_W   = $clog2(SLOTS + 1);

	// The code SLOTS marks the end of a chain.
	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(SLOTS);

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_DUP    = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_INS_FREE,
		S_INS_PREV,
		S_DEL_PREV,
		S_DEL_FREE,
		S_DONE
	} state_t;

	// Link of a slot that has not been written since reset or clear.
	function automatic logic [LINK_W-1:0] link_reset(input logic [SLOT_W-1:0] s);
		logic [LINK_W-1:0] r;
		if (s == SLOT_W'(SLOTS - 1)) begin
			r = NONE_LINK;
		end else begin
			r = LINK_W'(s) + LINK_W'(1);
		end
		return r;
	endfunction

endpackage

>>> src/ssll_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module ssll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/sorted_static_linked_list.sv
// Top level of the sorted static linked list: control sequencer, walk logic and memories.
`timescale 1ns / 1ps

// This block keeps a list of unique signed 32-bit keys in ascending order across 64 fixed
// slots, with the unused slots chained into a free list. A request carries its kind on
// s_tuser (insert, delete, search or clear) and the key on s_tdata; each request yields
// exactly one result with a status, the slot concerned and the element count after the
// request. The keys and the links sit in two RAMs with a registered read, and the walk
// follows the links at one slot per clock, because each read address is the link just
// read from the link RAM. A request therefore passes through acceptance, the walk over
// the links, one or two link updates for an insert or a delete, and the output
// register; clear and an insert into a full list skip the walk and the link updates.
// The block takes one request at a time, but a finished result waits in an output
// register, so a new request can be accepted while the previous result has not yet been
// taken. Links of slots not written since reset or the last clear read as their initial
// chain through valid bits, so neither reset nor clear needs a sweep over the memory.
module sorted_static_linked_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] key (signed)
	input  logic [1:0]  s_tuser,  // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [1:0] status, [7:2] slot, [14:8] element_count, [15] zero
);

	localparam int SLOT_W   = ssll_pkg::SLOT_W;
	localparam int LINK_W   = ssll_pkg::LINK_W;
	localparam int KEY_BITS = ssll_pkg::KEY_BITS;

	ssll_pkg::state_t state_q, state_d;

	// List bookkeeping, all in registers.
	logic [LINK_W-1:0]      list_head_q;
	logic [LINK_W-1:0]      free_head_q;
	logic [LINK_W-1:0]      count_q;
	logic [ssll_pkg::SLOTS-1:0] link_valid_q;

	// Request being served and the walk position.
	ssll_pkg::req_t         req_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [LINK_W-1:0]      cur_q;
	logic [LINK_W-1:0]      prev_q;
	logic [LINK_W-1:0]      steps_q;
	logic [LINK_W-1:0]      link_cur_q;
	ssll_pkg::status_t      status_q;
	logic [SLOT_W-1:0]      slot_q;

	// Output register.
	logic                   m_tvalid_q;
	logic [15:0]            m_tdata_q;

	// Memory ports.
	logic [SLOT_W-1:0]      rd_addr;
	logic [SLOT_W-1:0]      rd_addr_s1;
	logic                   rd_lvalid_s1;
	logic [KEY_BITS-1:0]    key_ram_q;
	logic [LINK_W-1:0]      link_ram_q;
	logic [LINK_W-1:0]      link_rd;
	logic                   link_we;
	logic [SLOT_W-1:0]      link_waddr;
	logic [LINK_W-1:0]      link_wdata;
	logic                   key_we;

	logic accept;
	logic out_free;
	logic walk_end_none;
	logic key_less;
	logic found;
	logic advance;
	logic prev_none;
	logic free_empty;

	assign s_tready = (state_q == ssll_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A link that has not been written since reset or clear reads as its initial value.
	assign link_rd = rd_lvalid_s1 ? link_ram_q : ssll_pkg::link_reset(rd_addr_s1);

	// The walk stops on an end-of-chain link or after visiting every slot. Otherwise the
	// key of the current slot is at the RAM output and decides whether to move on.
	assign walk_end_none = (cur_q >= LINK_W'(ssll_pkg::SLOTS))
		|| (steps_q >= LINK_W'(ssll_pkg::SLOTS));
	assign key_less   = $signed(key_ram_q) < key_q;
	assign advance    = !walk_end_none && key_less;
	assign found      = !walk_end_none && ($signed(key_ram_q) == key_q);
	assign prev_none  = (prev_q == ssll_pkg::NONE_LINK);
	assign free_empty = (free_head_q == ssll_pkg::NONE_LINK);

	ssll_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(ssll_pkg::SLOTS)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(free_head_q[SLOT_W-1:0]),
		.wdata(key_q),
		.raddr(rd_addr),
		.rdata(key_ram_q)
	);

	ssll_ram #(
		.WIDTH(LINK_W),
		.DEPTH(ssll_pkg::SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(rd_addr),
		.rdata(link_ram_q)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssll_pkg::S_IDLE: begin
				if (accept) begin
					if (ssll_pkg::req_t'(s_tuser) == ssll_pkg::REQ_CLEAR) begin
						state_d = ssll_pkg::S_DONE;
					end else if (ssll_pkg::req_t'(s_tuser) == ssll_pkg::REQ_INSERT
						&& free_empty) begin
						state_d = ssll_pkg::S_DONE;
					end else begin
						state_d = ssll_pkg::S_WALK;
					end
				end
			end
			ssll_pkg::S_WALK: begin
				if (!advance) begin
					unique case (req_q)
						ssll_pkg::REQ_INSERT: begin
							state_d = found ? ssll_pkg::S_DONE : ssll_pkg::S_INS_FREE;
						end
						ssll_pkg::REQ_DELETE: begin
							if (!found) begin
								state_d = ssll_pkg::S_DONE;
							end else if (prev_none) begin
								state_d = ssll_pkg::S_DEL_FREE;
							end else begin
								state_d = ssll_pkg::S_DEL_PREV;
							end
						end
						default: begin
							state_d = ssll_pkg::S_DONE;
						end
					endcase
				end
			end
			ssll_pkg::S_INS_FREE: begin
				state_d = prev_none ? ssll_pkg::S_DONE : ssll_pkg::S_INS_PREV;
			end
			ssll_pkg::S_INS_PREV: state_d = ssll_pkg::S_DONE;
			ssll_pkg::S_DEL_PREV: state_d = ssll_pkg::S_DEL_FREE;
			ssll_pkg::S_DEL_FREE: state_d = ssll_pkg::S_DONE;
			ssll_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ssll_pkg::S_IDLE;
				end
			end
			default: state_d = ssll_pkg::S_IDLE;
		endcase
	end

	// Memory controls. While walking, the next read address is the link just read, so the
	// walk advances one slot per cycle; when it stops, the free head is read for an insert.
	always_comb begin
		rd_addr    = list_head_q[SLOT_W-1:0];
		link_we    = 1'b0;
		link_waddr = prev_q[SLOT_W-1:0];
		link_wdata = link_cur_q;
		key_we     = 1'b0;
		unique case (state_q)
			ssll_pkg::S_WALK: begin
				rd_addr = advance ? link_rd[SLOT_W-1:0] : free_head_q[SLOT_W-1:0];
			end
			ssll_pkg::S_INS_FREE: begin
				link_we    = 1'b1;
				link_waddr = free_head_q[SLOT_W-1:0];
				link_wdata = cur_q;
				key_we     = 1'b1;
			end
			ssll_pkg::S_INS_PREV: begin
				link_we    = 1'b1;
				link_wdata = LINK_W'(slot_q);
			end
			ssll_pkg::S_DEL_PREV: begin
				link_we = 1'b1;
			end
			ssll_pkg::S_DEL_FREE: begin
				link_we    = 1'b1;
				link_waddr = cur_q[SLOT_W-1:0];
				link_wdata = free_head_q;
			end
			default: begin
			end
		endcase
	end

	// Read-side pipeline: address and valid bit travel alongside the RAM read.
	always_ff @(posedge clk) begin
		rd_addr_s1   <= rd_addr;
		rd_lvalid_s1 <= link_valid_q[rd_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ssll_pkg::S_IDLE;
			list_head_q  <= ssll_pkg::NONE_LINK;
			free_head_q  <= '0;
			count_q      <= '0;
			link_valid_q <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (link_we) begin
				link_valid_q[link_waddr] <= 1'b1;
			end
			unique case (state_q)
				ssll_pkg::S_IDLE: begin
					if (accept && ssll_pkg::req_t'(s_tuser) == ssll_pkg::REQ_CLEAR) begin
						list_head_q  <= ssll_pkg::NONE_LINK;
						free_head_q  <= '0;
						count_q      <= '0;
						link_valid_q <= '0;
					end
				end
				ssll_pkg::S_WALK: begin
					if (!advance && req_q == ssll_pkg::REQ_DELETE && found && prev_none) begin
						list_head_q <= link_rd;
					end
				end
				ssll_pkg::S_INS_FREE: begin
					free_head_q <= link_rd;
					count_q     <= count_q + LINK_W'(1);
					if (prev_none) begin
						list_head_q <= free_head_q;
					end
				end
				ssll_pkg::S_DEL_FREE: begin
					free_head_q <= cur_q;
					if (count_q != '0) begin
						count_q <= count_q - LINK_W'(1);
					end
				end
				default: begin
				end
			endcase
			if (state_q == ssll_pkg::S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request and walk registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ssll_pkg::S_IDLE: begin
				if (accept) begin
					req_q    <= ssll_pkg::req_t'(s_tuser);
					key_q    <= s_tdata;
					cur_q    <= list_head_q;
					prev_q   <= ssll_pkg::NONE_LINK;
					steps_q  <= '0;
					slot_q   <= '0;
					status_q <= (ssll_pkg::req_t'(s_tuser) == ssll_pkg::REQ_INSERT && free_empty)
						? ssll_pkg::ST_FULL : ssll_pkg::ST_OK;
				end
			end
			ssll_pkg::S_WALK: begin
				if (advance) begin
					prev_q  <= cur_q;
					cur_q   <= link_rd;
					steps_q <= steps_q + LINK_W'(1);
				end else begin
					link_cur_q <= link_rd;
					if (req_q == ssll_pkg::REQ_INSERT) begin
						if (found) begin
							status_q <= ssll_pkg::ST_DUP;
						end
					end else if (!found) begin
						status_q <= ssll_pkg::ST_ABSENT;
					end else if (req_q == ssll_pkg::REQ_SEARCH) begin
						slot_q <= cur_q[SLOT_W-1:0];
					end
				end
			end
			ssll_pkg::S_INS_FREE: begin
				slot_q <= free_head_q[SLOT_W-1:0];
			end
			ssll_pkg::S_DEL_FREE: begin
				slot_q <= cur_q[SLOT_W-1:0];
			end
			ssll_pkg::S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {1'b0, count_q, slot_q, status_q};
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// The free chain is empty exactly when every slot holds a key.
	a_free_vs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == ssll_pkg::NONE_LINK) == (count_q == LINK_W'(ssll_pkg::SLOTS)))
		else $error("free chain and element count disagree");

	// A clear request leaves an empty list and a full free chain behind it.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ssll_pkg::req_t'(s_tuser) == ssll_pkg::REQ_CLEAR) |=>
		(list_head_q == ssll_pkg::NONE_LINK && count_q == '0 && free_head_q == '0))
		else $error("clear did not reset the list");

	// A refused request always reports slot zero.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tdata_q[1:0] != ssll_pkg::ST_OK) |-> (m_tdata_q[7:2] == '0))
		else $error("refused request reports a slot");

	// The walk never goes beyond one visit per slot.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssll_pkg::S_WALK) |-> (steps_q <= LINK_W'(ssll_pkg::SLOTS)))
		else $error("walk exceeded the slot count");
`endif

endmodule

>>> test/sorted_static_linked_list_test.sv
// Self-checking testbench for the sorted static linked list, with a shadow list model.
`timescale 1ns / 1ps

module sorted_static_linked_list_test;

	import ssll_pkg::*;

	localparam int POOL_SIZE     = 96;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int IDLE_PERCENT  = 11;
	localparam int HOLD_AFTER    = 300;   // results taken before the long receiver hold-off
	localparam int HOLD_CYCLES   = 400;
	localparam int STEADY_FROM   = 500;   // window in which neither side idles
	localparam int STEADY_TO     = 650;
	localparam int DRAIN_CYCLES  = 80;
	localparam int STALL_LIMIT   = 5000;

	typedef struct packed {
		req_t                kind;
		logic [KEY_BITS-1:0] key;
	} list_request_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [LINK_W-1:0] count;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	sorted_static_linked_list dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the list: keys, links, both chain heads and the element count.
	logic signed [KEY_BITS-1:0] shadow_keys [SLOTS];
	logic [LINK_W-1:0]          shadow_links [SLOTS];
	logic [LINK_W-1:0]          shadow_head;
	logic [LINK_W-1:0]          shadow_free;
	logic [LINK_W-1:0]          shadow_count;

	list_request_t request_q [$];
	list_result_t  awaited_results [$];
	logic [31:0]   key_pool [POOL_SIZE];

	int requests_total = 0;
	int requests_taken = 0;
	int results_taken = 0;
	int mismatches = 0;
	int failures = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int kind_seen [4];
	int status_seen [4];
	int peak_count = 0;

	list_request_t offered;
	list_result_t  outcome;
	list_result_t  wanted;

	task automatic rebuild_chains();
		for (int i = 0; i < SLOTS; i++) begin
			shadow_links[i] = (i == SLOTS - 1) ? NONE_LINK : LINK_W'(i + 1);
		end
		shadow_head  = NONE_LINK;
		shadow_free  = '0;
		shadow_count = '0;
	endtask

	// Finds the first slot whose key is not below k, and the slot before it.
	task automatic find_position(input logic signed [KEY_BITS-1:0] k,
			output logic [LINK_W-1:0] cur, output logic [LINK_W-1:0] prev);
		int steps;
		cur   = shadow_head;
		prev  = NONE_LINK;
		steps = 0;
		while (cur < SLOTS && steps < SLOTS && shadow_keys[cur[SLOT_W-1:0]] < k) begin
			prev = cur;
			cur  = shadow_links[cur[SLOT_W-1:0]];
			steps++;
		end
		if (cur >= SLOTS || steps >= SLOTS) begin
			cur = NONE_LINK;
		end
	endtask

	task automatic apply_to_shadow_list(input req_t kind, input logic signed [KEY_BITS-1:0] k,
			output list_result_t res);
		logic [LINK_W-1:0] cur;
		logic [LINK_W-1:0] prev;
		logic [LINK_W-1:0] fresh;
		res.status = ST_OK;
		res.slot   = '0;
		case (kind)
			REQ_CLEAR: begin
				rebuild_chains();
			end
			REQ_INSERT: begin
				// A full list is reported before any walk, even for a present key.
				if (shadow_free >= SLOTS) begin
					res.status = ST_FULL;
				end else begin
					find_position(k, cur, prev);
					if (cur != NONE_LINK && shadow_keys[cur[SLOT_W-1:0]] == k) begin
						res.status = ST_DUP;
					end else begin
						fresh                            = shadow_free;
						shadow_free                      = shadow_links[fresh[SLOT_W-1:0]];
						shadow_keys[fresh[SLOT_W-1:0]]   = k;
						if (prev == NONE_LINK) begin
							shadow_links[fresh[SLOT_W-1:0]] = shadow_head;
							shadow_head                     = fresh;
						end else begin
							shadow_links[fresh[SLOT_W-1:0]] = shadow_links[prev[SLOT_W-1:0]];
							shadow_links[prev[SLOT_W-1:0]]  = fresh;
						end
						shadow_count++;
						res.slot = fresh[SLOT_W-1:0];
					end
				end
			end
			default: begin
				find_position(k, cur, prev);
				if (cur == NONE_LINK || shadow_keys[cur[SLOT_W-1:0]] != k) begin
					res.status = ST_ABSENT;
				end else begin
					res.slot = cur[SLOT_W-1:0];
					if (kind == REQ_DELETE) begin
						// The freed slot goes to the front of the free chain.
						if (prev == NONE_LINK) begin
							shadow_head = shadow_links[cur[SLOT_W-1:0]];
						end else begin
							shadow_links[prev[SLOT_W-1:0]] = shadow_links[cur[SLOT_W-1:0]];
						end
						shadow_links[cur[SLOT_W-1:0]] = shadow_free;
						shadow_free                   = cur;
						if (shadow_count > 0) begin
							shadow_count--;
						end
					end
				end
			end
		endcase
		res.count = shadow_count;
		kind_seen[kind]++;
		status_seen[res.status]++;
		if (shadow_count > peak_count) begin
			peak_count = int'(shadow_count);
		end
	endtask

	task automatic add_request(input req_t kind, input logic [KEY_BITS-1:0] key);
		list_request_t r;
		r.kind = kind;
		r.key  = key;
		request_q.push_back(r);
		requests_total++;
	endtask

	// Mostly keys from the current pool, so that requests hit stored keys; some fully random.
	function automatic logic [KEY_BITS-1:0] draw_key();
		if ($urandom_range(99) < 15) begin
			return $urandom;
		end
		return key_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	task automatic refill_pool();
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++) begin
			if ($urandom_range(1) == 0) begin
				key_pool[i] = 32'($urandom_range(200)) - 32'd100;
			end else begin
				key_pool[i] = $urandom;
			end
		end
	endtask

	// Request driver: the prediction is made at the edge where a request is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_to_shadow_list(req_t'(s_tuser), s_tdata, outcome);
				awaited_results.push_back(outcome);
				requests_taken <= requests_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (request_q.size() != 0 && ((requests_taken >= STEADY_FROM &&
						requests_taken < STEADY_TO) || $urandom_range(99) >= IDLE_PERCENT)) begin
					offered = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= offered.kind;
					s_tdata  <= offered.key;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver readiness, with one long hold-off so that the block backs up into its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_taken >= HOLD_AFTER) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (results_taken >= STEADY_FROM && results_taken < STEADY_TO) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_taken <= results_taken + 1;
			if (awaited_results.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("Unexpected result %h with no request outstanding", m_tdata);
				end
			end else begin
				wanted = awaited_results.pop_front();
				if (m_tdata[1:0] !== wanted.status || m_tdata[7:2] !== wanted.slot ||
						m_tdata[14:8] !== wanted.count || m_tdata[15] !== 1'b0) begin
					mismatches++;
					failures++;
					if (mismatches <= 10) begin
						$display("Result %0d: expected status %0d slot %0d count %0d pad 0,",
							results_taken, wanted.status, wanted.slot, wanted.count,
							" got status %0d slot %0d count %0d pad %0b",
							m_tdata[1:0], m_tdata[7:2], m_tdata[14:8], m_tdata[15]);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no accepted request or result.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int mode;
		int phase_len;
		int roll;
		int made;
		req_t kind;

		rebuild_chains();
		for (int i = 0; i < SLOTS; i++) begin
			shadow_keys[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			kind_seen[i]   = 0;
			status_seen[i] = 0;
		end

		// Directed part: key extremes, every request kind, duplicates, absent keys,
		// deletes at the head, middle and tail, slot reuse and clear.
		add_request(REQ_INSERT, 32'h0000_0000);
		add_request(REQ_INSERT, 32'h7fff_ffff);
		add_request(REQ_INSERT, 32'h8000_0000);
		add_request(REQ_INSERT, 32'hffff_ffff);
		add_request(REQ_INSERT, 32'h0000_0001);
		add_request(REQ_INSERT, 32'h0000_0000);
		add_request(REQ_SEARCH, 32'h8000_0000);
		add_request(REQ_SEARCH, 32'h7fff_ffff);
		add_request(REQ_SEARCH, 32'h0000_0005);
		add_request(REQ_DELETE, 32'h0000_0005);
		add_request(REQ_DELETE, 32'h8000_0000);
		add_request(REQ_DELETE, 32'h0000_0000);
		add_request(REQ_DELETE, 32'h7fff_ffff);
		add_request(REQ_SEARCH, 32'h0000_0000);
		add_request(REQ_INSERT, 32'h5555_5555);
		add_request(REQ_INSERT, 32'haaaa_aaaa);
		add_request(REQ_SEARCH, 32'haaaa_aaaa);
		add_request(REQ_CLEAR,  32'hffff_ffff);
		add_request(REQ_SEARCH, 32'hffff_ffff);
		add_request(REQ_DELETE, 32'h0000_0001);
		add_request(REQ_INSERT, 32'h0000_0007);
		add_request(REQ_CLEAR,  32'h0000_0000);

		// Random part in phases: filling phases push the list to full, draining phases
		// empty it again, mixed phases also clear it now and then.
		refill_pool();
		made = 0;
		while (made < RANDOM_ITEMS) begin
			mode = $urandom_range(2);
			phase_len = (mode == 0) ? $urandom_range(200, 120) : $urandom_range(150, 60);
			if ($urandom_range(1) == 0) begin
				refill_pool();
			end
			for (int i = 0; i < phase_len && made < RANDOM_ITEMS; i++) begin
				roll = $urandom_range(99);
				case (mode)
					0: kind = (roll < 72) ? REQ_INSERT : (roll < 82) ? REQ_DELETE : REQ_SEARCH;
					1: kind = (roll < 15) ? REQ_INSERT : (roll < 75) ? REQ_DELETE : REQ_SEARCH;
					default: kind = (roll < 35) ? REQ_INSERT : (roll < 65) ? REQ_DELETE :
						(roll < 96) ? REQ_SEARCH : REQ_CLEAR;
				endcase
				add_request(kind, draw_key());
				made++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (requests_taken != requests_total) begin
			@(posedge clk);
		end
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d inserts, %0d deletes, %0d searches, %0d clears.",
			requests_taken, kind_seen[REQ_INSERT], kind_seen[REQ_DELETE],
			kind_seen[REQ_SEARCH], kind_seen[REQ_CLEAR]);
		$display("Outcomes: %0d done, %0d full, %0d duplicate, %0d absent; longest list %0d keys.",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
			status_seen[ST_ABSENT], peak_count);
		if (failures == 0 && awaited_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/ssll_pkg.sv
src/ssll_ram.sv
src/sorted_static_linked_list.sv
test/sorted_static_linked_list_test.sv
